// File: rtl/core/delta_varint_sample_encoder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delta varint sample encoder
// Shared implication checks, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef DELTA_VARINT_SAMPLE_ENCODER_DEFINES_SVH
`define DELTA_VARINT_SAMPLE_ENCODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DVE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DVE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/dve_pkg.sv
// ----------------------------------------------------------------------------
// dve_pkg
// Types and constants shared by the delta varint sample encoder.
// ----------------------------------------------------------------------------
package dve_pkg;

    localparam int unsigned SampleWidth = 32;
    localparam int unsigned AddrWidth   = 3;

    localparam logic [7:0] SignFlag = 8'h01;
    localparam logic [7:0] MoreFlag = 8'h80;

    // Register map, decoded on paddr[2].
    localparam logic RegNarrowSamples = 1'b0;

    // Result of the shared subtract unit.
    typedef struct packed {
        logic [SampleWidth-1:0] value;   // difference, wrapped to the sample width
        logic                   top;     // difference is the most negative value
        logic                   neg;     // sign bit of the difference
    } alu_res_t;

endpackage

// File: rtl/core/dve_channels.sv
// ----------------------------------------------------------------------------
// Channel interfaces
// Valid/ready request channels for incoming samples and outgoing code bytes.
// ----------------------------------------------------------------------------
interface dve_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [dve_pkg::SampleWidth-1:0] sample;
    logic                                first_of_block;

    modport source (output valid, sample, first_of_block, input ready);
    modport sink   (input valid, sample, first_of_block, output ready);
endinterface

interface dve_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last_byte;
    logic       clipped;

    modport source (output valid, code_byte, last_byte, clipped, input ready);
    modport sink   (input valid, code_byte, last_byte, clipped, output ready);
endinterface

// File: rtl/core/dve_alu.sv
// ----------------------------------------------------------------------------
// dve_alu
// Shared subtractor: a - b wrapped to 16 or 32 bits, with sign and
// most-negative flags. Used for the difference and for the negation.
// ----------------------------------------------------------------------------
module dve_alu
(
    input  logic [dve_pkg::SampleWidth-1:0] a,
    input  logic [dve_pkg::SampleWidth-1:0] b,
    input  logic                            narrow,
    output dve_pkg::alu_res_t               res
);

    logic [dve_pkg::SampleWidth-1:0] diff;
    logic [dve_pkg::SampleWidth-1:0] wrapped;
    logic                            sign;
    logic                            low_zero;

    always_comb
    begin
        diff = a - b;
        if (narrow)
        begin
            wrapped  = {16'h0000, diff[15:0]};
            sign     = diff[15];
            low_zero = (diff[14:0] == 15'h0000);
        end
        else
        begin
            wrapped  = diff;
            sign     = diff[31];
            low_zero = (diff[30:0] == 31'h0000_0000);
        end
        res.value = wrapped;
        res.neg   = sign;
        res.top   = sign && low_zero;
    end

endmodule

// File: rtl/core/delta_varint_sample_encoder.sv
// ----------------------------------------------------------------------------
// delta_varint_sample_encoder
// Each accepted sample is coded as its difference from the previous sample
// (or against zero when first_of_block is set), wrapped at 16 or 32 bits per
// the narrow_samples register, and sent as sign-magnitude varint bytes: the
// first byte holds the sign in bit 0 and six magnitude bits, later bytes seven
// bits each, bit 7 set while more bytes follow. A most-negative difference
// yields a single byte of zero with clipped and last_byte set. A sample is
// accepted in ST_IDLE, its difference formed in ST_DIFF, negated in ST_NEGATE
// only when the difference is negative, then sent in ST_EMIT at one byte per
// cycle (one to five bytes) while the output register is free to take one; both
// subtractions go through a single shared subtractor and the bytes leave
// through one output register. The input is not ready until the last byte of
// the current sample has moved into the output register.
// ----------------------------------------------------------------------------
`include "delta_varint_sample_encoder_defines.svh"

module delta_varint_sample_encoder
(
    input  logic                            clk,
    input  logic                            rst_n,
    dve_sample_if.sink                      samples,
    dve_code_if.source                      codes,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dve_pkg::AddrWidth-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIFF,
        ST_NEGATE,
        ST_EMIT
    } state_t;

    state_t                          state_reg, state_next;
    logic                            narrow_reg, narrow_next;
    logic [dve_pkg::SampleWidth-1:0] sample_reg, sample_next;
    logic                            first_reg, first_next;
    logic [dve_pkg::SampleWidth-1:0] prev_reg, prev_next;
    logic [dve_pkg::SampleWidth-1:0] mag_reg, mag_next;
    logic                            sign_reg, sign_next;
    logic                            clip_reg, clip_next;
    logic                            lead_reg, lead_next;
    logic                            out_valid_reg, out_valid_next;
    logic [7:0]                      out_byte_reg, out_byte_next;
    logic                            out_last_reg, out_last_next;
    logic                            out_clip_reg, out_clip_next;

    logic [dve_pkg::SampleWidth-1:0] alu_a;
    logic [dve_pkg::SampleWidth-1:0] alu_b;
    dve_pkg::alu_res_t               alu_res;

    logic                            in_take;
    logic                            out_free;
    logic                            cfg_write;
    logic [dve_pkg::SampleWidth-1:0] mag_rest;
    logic [6:0]                      group_bits;
    logic                            more;

    dve_alu u_alu
    (
        .a      (alu_a),
        .b      (alu_b),
        .narrow (narrow_reg),
        .res    (alu_res)
    );

    assign samples.ready = (state_reg == ST_IDLE);
    assign in_take       = samples.valid && samples.ready;
    assign out_free      = !out_valid_reg || codes.ready;

    assign codes.valid     = out_valid_reg;
    assign codes.code_byte = out_byte_reg;
    assign codes.last_byte = out_last_reg;
    assign codes.clipped   = out_clip_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == dve_pkg::RegNarrowSamples) ? {31'h0, narrow_reg} : 32'h0;

    // The subtractor forms the difference first, then the negated magnitude.
    always_comb
    begin
        if (state_reg == ST_NEGATE)
        begin
            alu_a = '0;
            alu_b = mag_reg;
        end
        else
        begin
            alu_a = sample_reg;
            alu_b = first_reg ? '0 : prev_reg;
        end
    end

    // The first byte takes six magnitude bits next to the sign, later bytes seven.
    always_comb
    begin
        if (lead_reg)
        begin
            mag_rest   = mag_reg >> 6;
            group_bits = {mag_reg[5:0], sign_reg};
        end
        else
        begin
            mag_rest   = mag_reg >> 7;
            group_bits = mag_reg[6:0];
        end
        more = (mag_rest != '0);
    end

    always_comb
    begin
        state_next     = state_reg;
        narrow_next    = narrow_reg;
        sample_next    = sample_reg;
        first_next     = first_reg;
        prev_next      = prev_reg;
        mag_next       = mag_reg;
        sign_next      = sign_reg;
        clip_next      = clip_reg;
        lead_next      = lead_reg;
        out_valid_next = out_valid_reg && !codes.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_clip_next  = out_clip_reg;

        if (cfg_write && (paddr[2] == dve_pkg::RegNarrowSamples))
        begin
            narrow_next = pwdata[0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    sample_next = samples.sample;
                    first_next  = samples.first_of_block;
                    state_next  = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                prev_next = sample_reg;
                mag_next  = alu_res.value;
                sign_next = alu_res.neg;
                clip_next = alu_res.top;
                lead_next = 1'b1;
                if (alu_res.neg && !alu_res.top)
                begin
                    state_next = ST_NEGATE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_NEGATE:
            begin
                mag_next   = alu_res.value;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (clip_reg)
                    begin
                        out_byte_next = '0;
                        out_last_next = 1'b1;
                        out_clip_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        out_byte_next = {(more ? dve_pkg::MoreFlag[7] : 1'b0), group_bits};
                        out_last_next = !more;
                        out_clip_next = 1'b0;
                        mag_next      = mag_rest;
                        lead_next     = 1'b0;
                        if (!more)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            narrow_reg    <= 1'b0;
            sample_reg    <= '0;
            first_reg     <= 1'b0;
            prev_reg      <= '0;
            mag_reg       <= '0;
            sign_reg      <= 1'b0;
            clip_reg      <= 1'b0;
            lead_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_clip_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            narrow_reg    <= narrow_next;
            sample_reg    <= sample_next;
            first_reg     <= first_next;
            prev_reg      <= prev_next;
            mag_reg       <= mag_next;
            sign_reg      <= sign_next;
            clip_reg      <= clip_next;
            lead_reg      <= lead_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
            out_clip_reg  <= out_clip_next;
        end
    end

    `DVE_ASSERT_SAME(a_clip_single, out_valid_reg && out_clip_reg,
        out_last_reg && (out_byte_reg == 8'h00), "clipped result must be a lone zero byte")
    `DVE_ASSERT_SAME(a_more_flag, out_valid_reg && !out_clip_reg,
        out_byte_reg[7] == !out_last_reg, "continuation bit disagrees with last_byte")
    `DVE_ASSERT_NEXT(a_take_busy, in_take, state_reg == ST_DIFF,
        "accepted sample did not start the difference step")
    `DVE_ASSERT_SAME(a_narrow_mag, (state_reg == ST_EMIT) && narrow_reg,
        mag_reg[31:16] == 16'h0000, "narrow magnitude exceeds 16 bits")

endmodule
